// File: hdl/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// shared types and constants for the counter frame parser
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int NUM_TALLIES = 5;
  localparam int TALLY_IDX_W = 3;

  localparam logic [7:0] CMD_CLEAR_ALL = 8'h71;
  localparam logic [7:0] CMD_TALLY_MAX = 8'(NUM_TALLIES);

  // result kind codes
  typedef enum logic [2:0] {
    KIND_SET_OK    = 3'd0,
    KIND_REPORT    = 3'd1,
    KIND_CRC_ERR   = 3'd2,
    KIND_BAD_START = 3'd3,
    KIND_IGNORED   = 3'd4
  } kind_t;

  // work handed from the parser to the executor
  typedef enum logic [1:0] {
    JOB_BAD_START = 2'd0,
    JOB_CRC_ERR   = 2'd1,
    JOB_SET       = 2'd2,
    JOB_REPORT    = 2'd3
  } job_op_t;

  typedef struct packed {
    job_op_t     op;
    logic [7:0]  cmd;
    logic [15:0] value;
  } job_t;

  // queue handshake toward each side
  typedef struct packed {
    logic full;
    logic vld;
  } q_status_t;

  // report message phase within one tally
  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } rpt_phase_t;

  typedef enum logic {
    BK_IDLE   = 1'b0,
    BK_REPORT = 1'b1
  } back_state_t;

endpackage

// File: hdl/counter_frame_parser.sv
// ----------------------------------------------------------------------------
// counter_frame_parser
// serial frame parser keeping five 16-bit tallies, with report streaming
// ----------------------------------------------------------------------------
// usage
//   in_*  : one received byte per beat, plus a line abort flag that drops a
//           partial frame (the byte of that beat is ignored)
//   out_* : result beats (kind, out_byte, last); a report frame gives 15
//           beats, any other frame end or bad opener gives one
//   cfg_* : writes the set and report start bytes, always ready
// timing: a closing byte (or a bad opener) becomes a queued job, and its
//   result beat is then registered at the output; a report's 15 beats follow
//   back to back from the report state while out_ready stays high
// throughput: one byte per cycle while the two-entry job queue has room;
//   the report stream in the executor is what holds input back
// reset: start bytes return to 2 and 3, parser waits for an opener,
//   tallies clear, queue and output register empty
// stall: while out_ready is low the output register holds its beat, the
//   executor stops, the queue fills and then in_ready drops
// ----------------------------------------------------------------------------
module counter_frame_parser #(
  parameter int SET_FRAME_LEN    = 5,
  parameter int REPORT_FRAME_LEN = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  // byte input
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_line_abort,
  // result output
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  // jobs from parser to executor
  logic               push;
  cfp_pkg::job_t      push_job;
  cfp_pkg::job_t      head_job;
  logic               pop;
  cfp_pkg::q_status_t q_status;

  // front: frame tracking, checksum, start byte registers
  cfp_front #(
    .SET_FRAME_LEN    (SET_FRAME_LEN),
    .REPORT_FRAME_LEN (REPORT_FRAME_LEN)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .in_line_abort (in_line_abort),
    .q_full        (q_status.full),
    .push          (push),
    .push_job      (push_job)
  );

  // decoupling queue, order of jobs is kept so reports see earlier sets
  cfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  // back: tallies and registered result beats
  cfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_status.vld),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// File: hdl/cfp_front.sv
// ----------------------------------------------------------------------------
// cfp_front
// byte parser: tracks the partial frame and hands finished frames on as jobs
// ----------------------------------------------------------------------------
module cfp_front #(
  parameter int SET_FRAME_LEN    = 5,
  parameter int REPORT_FRAME_LEN = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_rx_byte,
  input  logic          in_line_abort,
  input  logic          q_full,
  output logic          push,
  output cfp_pkg::job_t push_job
);

  localparam logic [4:0] SET_LEN = 5'(SET_FRAME_LEN);
  localparam logic [4:0] RPT_LEN = 5'(REPORT_FRAME_LEN);

  logic [7:0] set_start_r, set_start_nxt;
  logic [7:0] rpt_start_r, rpt_start_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic       ftype_r, ftype_nxt;
  logic [6:0] sum_r, sum_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] dhi_r, dhi_nxt;
  logic [7:0] dlo_r, dlo_nxt;
  logic       accept;
  logic [4:0] flen;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign flen      = ftype_r ? RPT_LEN : SET_LEN;

  always_comb begin
    set_start_nxt = set_start_r;
    rpt_start_nxt = rpt_start_r;
    pos_nxt       = pos_r;
    ftype_nxt     = ftype_r;
    sum_nxt       = sum_r;
    cmd_nxt       = cmd_r;
    dhi_nxt       = dhi_r;
    dlo_nxt       = dlo_r;
    push          = 1'b0;
    push_job.op    = cfp_pkg::JOB_BAD_START;
    push_job.cmd   = cmd_r;
    push_job.value = {dhi_r, dlo_r};

    if (cfg_valid) begin
      if (cfg_index == 1'b0) set_start_nxt = cfg_data;
      else                   rpt_start_nxt = cfg_data;
    end

    if (accept) begin
      if (in_line_abort) begin
        pos_nxt = 4'd0;
      end else if (pos_r == 4'd0) begin
        if (in_rx_byte == set_start_r || in_rx_byte == rpt_start_r) begin
          ftype_nxt = (in_rx_byte != set_start_r);
          pos_nxt   = 4'd1;
          sum_nxt   = 7'd0;
          cmd_nxt   = 8'd0;
          dhi_nxt   = 8'd0;
          dlo_nxt   = 8'd0;
        end else begin
          push        = 1'b1;
          push_job.op = cfp_pkg::JOB_BAD_START;
        end
      end else if ({1'b0, pos_r} + 5'd1 < flen) begin
        sum_nxt = sum_r + in_rx_byte[6:0];
        case (pos_r)
          4'd1:    cmd_nxt = in_rx_byte;
          4'd2:    dhi_nxt = in_rx_byte;
          4'd3:    dlo_nxt = in_rx_byte;
          default: ;
        endcase
        pos_nxt = pos_r + 4'd1;
      end else begin
        // checksum byte closes the frame
        pos_nxt = 4'd0;
        push    = 1'b1;
        if (in_rx_byte != {1'b0, sum_r}) push_job.op = cfp_pkg::JOB_CRC_ERR;
        else if (ftype_r)                push_job.op = cfp_pkg::JOB_REPORT;
        else                             push_job.op = cfp_pkg::JOB_SET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_start_r <= 8'd2;
      rpt_start_r <= 8'd3;
      pos_r       <= 4'd0;
      ftype_r     <= 1'b0;
      sum_r       <= 7'd0;
      cmd_r       <= 8'd0;
      dhi_r       <= 8'd0;
      dlo_r       <= 8'd0;
    end else begin
      set_start_r <= set_start_nxt;
      rpt_start_r <= rpt_start_nxt;
      pos_r       <= pos_nxt;
      ftype_r     <= ftype_nxt;
      sum_r       <= sum_nxt;
      cmd_r       <= cmd_nxt;
      dhi_r       <= dhi_nxt;
      dlo_r       <= dlo_nxt;
    end
  end

endmodule

// File: hdl/cfp_queue.sv
// ----------------------------------------------------------------------------
// cfp_queue
// two-entry job queue between parser and executor
// ----------------------------------------------------------------------------
module cfp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  cfp_pkg::job_t        push_job,
  input  logic                 pop,
  output cfp_pkg::job_t        head_job,
  output cfp_pkg::q_status_t   status
);

  cfp_pkg::job_t mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign status.full = (cnt_r == 2'd2);
  assign status.vld  = (cnt_r != 2'd0);
  assign head_job    = mem_r[rd_ptr_r];
  assign do_push     = push && !status.full;
  assign do_pop      = pop && status.vld;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: hdl/cfp_back.sv
// ----------------------------------------------------------------------------
// cfp_back
// job executor: owns the tallies, applies set jobs, streams report messages
// ----------------------------------------------------------------------------
module cfp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_vld,
  input  cfp_pkg::job_t      head_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_byte,
  output logic               out_last
);

  cfp_pkg::back_state_t      state_r, state_nxt;
  cfp_pkg::rpt_phase_t       ph_r, ph_nxt;
  logic [cfp_pkg::TALLY_IDX_W-1:0] tly_r, tly_nxt;
  logic [15:0] tallies_r [cfp_pkg::NUM_TALLIES];
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_kind_r, out_kind_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_free;
  logic        ld_en, clr_en;
  logic [15:0] cur_tally;

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_free  = !out_valid_r || out_ready;
  assign cur_tally = tallies_r[tly_r];

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    tly_nxt       = tly_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    ld_en         = 1'b0;
    clr_en        = 1'b0;

    case (state_r)
      cfp_pkg::BK_IDLE: begin
        if (q_vld && out_free) begin
          pop          = 1'b1;
          out_byte_nxt = 8'd0;
          out_last_nxt = 1'b1;
          case (head_job.op)
            cfp_pkg::JOB_BAD_START: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = cfp_pkg::KIND_BAD_START;
            end
            cfp_pkg::JOB_CRC_ERR: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = cfp_pkg::KIND_CRC_ERR;
            end
            cfp_pkg::JOB_SET: begin
              out_valid_nxt = 1'b1;
              if (head_job.cmd < cfp_pkg::CMD_TALLY_MAX) begin
                ld_en        = 1'b1;
                out_kind_nxt = cfp_pkg::KIND_SET_OK;
              end else if (head_job.cmd == cfp_pkg::CMD_CLEAR_ALL) begin
                clr_en       = 1'b1;
                out_kind_nxt = cfp_pkg::KIND_SET_OK;
              end else begin
                out_kind_nxt = cfp_pkg::KIND_IGNORED;
              end
            end
            default: begin
              // report: switch to the streaming state
              state_nxt = cfp_pkg::BK_REPORT;
              tly_nxt   = '0;
              ph_nxt    = cfp_pkg::PH_TAG;
            end
          endcase
        end
      end
      default: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = cfp_pkg::KIND_REPORT;
          out_last_nxt  = 1'b0;
          case (ph_r)
            cfp_pkg::PH_TAG: begin
              out_byte_nxt = (tly_r == '0) ? 8'd1 : 8'(tly_r);
              ph_nxt       = cfp_pkg::PH_HIGH;
            end
            cfp_pkg::PH_HIGH: begin
              out_byte_nxt = cur_tally[15:8];
              ph_nxt       = cfp_pkg::PH_LOW;
            end
            default: begin
              out_byte_nxt = cur_tally[7:0];
              ph_nxt       = cfp_pkg::PH_TAG;
              tly_nxt      = tly_r + 1'b1;
              if (tly_r == cfp_pkg::TALLY_IDX_W'(cfp_pkg::NUM_TALLIES - 1)) begin
                out_last_nxt = 1'b1;
                state_nxt    = cfp_pkg::BK_IDLE;
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cfp_pkg::NUM_TALLIES; i++) tallies_r[i] <= 16'd0;
    end else if (clr_en) begin
      for (int i = 0; i < cfp_pkg::NUM_TALLIES; i++) tallies_r[i] <= 16'd0;
    end else if (ld_en) begin
      tallies_r[head_job.cmd[cfp_pkg::TALLY_IDX_W-1:0]] <= head_job.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfp_pkg::BK_IDLE;
      ph_r        <= cfp_pkg::PH_TAG;
      tly_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      tly_r       <= tly_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// File: test/tb_counter_frame_parser.sv
// ----------------------------------------------------------------------------
// tb_counter_frame_parser
// drives serial bytes and line aborts into the frame parser, predicts every
// result beat with an in-bench tally model and compares beat by beat, over
// several start byte settings and idle/stall mixes
// ----------------------------------------------------------------------------
module tb_counter_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  // frame lengths, opener and checksum included
  localparam int SET_LEN       = 5;
  localparam int REPORT_LEN    = 5;
  // cycles without any handshake before the run is declared hung
  localparam int QUIET_LIMIT   = 2000;
  // report stream plus pipeline, waited out after the last result
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_PRINTS    = 40;

  // configuration register indexes
  localparam logic REG_SET_START    = 1'b0;
  localparam logic REG_REPORT_START = 1'b1;

  typedef struct packed {
    cfp_pkg::kind_t kind;
    logic [7:0]     data;
    logic           last;
  } result_t;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       cfg_valid     = 1'b0;
  logic       cfg_index     = REG_SET_START;
  logic [7:0] cfg_data      = 8'h00;
  logic       in_valid      = 1'b0;
  logic [7:0] in_rx_byte    = 8'h00;
  logic       in_line_abort = 1'b0;
  logic       out_ready     = 1'b0;
  logic       cfg_ready;
  logic       in_ready;
  logic       out_valid;
  logic [2:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  // idle percentages of sender and receiver, changed per phase
  int send_pct  = 0;
  int stall_pct = 0;
  int errors    = 0;

  // results still owed by the block, oldest first
  result_t expected_results[$];

  // tally model state
  logic [7:0]  m_set_start;
  logic [7:0]  m_report_start;
  logic [3:0]  m_pos;
  logic        m_report;
  logic [6:0]  m_sum;
  logic [7:0]  m_cmd;
  logic [7:0]  m_hi;
  logic [7:0]  m_lo;
  logic [15:0] m_tally [cfp_pkg::NUM_TALLIES];

  counter_frame_parser #(
    .SET_FRAME_LEN   (SET_LEN),
    .REPORT_FRAME_LEN(REPORT_LEN)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .in_line_abort(in_line_abort),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // tally model
  // ---------------------------------------------------------------------------

  function automatic void model_reset();
    m_set_start    = 8'd2;
    m_report_start = 8'd3;
    m_pos          = '0;
    m_report       = 1'b0;
    m_sum          = '0;
    m_cmd          = '0;
    m_hi           = '0;
    m_lo           = '0;
    for (int k = 0; k < cfp_pkg::NUM_TALLIES; k++) m_tally[k] = '0;
  endfunction

  function automatic void owe_result(cfp_pkg::kind_t k, logic [7:0] d, logic l);
    result_t r;
    r.kind = k;
    r.data = d;
    r.last = l;
    expected_results.push_back(r);
  endfunction

  // advance the model by one accepted input beat and queue what it causes
  function automatic void predict_results(logic [7:0] b, logic abort);
    int flen;
    flen = m_report ? REPORT_LEN : SET_LEN;
    if (abort) begin
      // abort drops any partial frame, byte itself is ignored
      m_pos = '0;
    end else if (m_pos == 4'd0) begin
      // waiting for an opener; set wins when both start bytes are equal
      if (b == m_set_start || b == m_report_start) begin
        m_report = (b != m_set_start);
        m_pos    = 4'd1;
        m_sum    = '0;
        m_cmd    = '0;
        m_hi     = '0;
        m_lo     = '0;
      end else begin
        owe_result(cfp_pkg::KIND_BAD_START, 8'h00, 1'b1);
      end
    end else if (int'(m_pos) + 1 < flen) begin
      // body byte: accumulate 7-bit sum, latch command and data
      m_sum = m_sum + b[6:0];
      case (m_pos)
        4'd1: m_cmd = b;
        4'd2: m_hi  = b;
        4'd3: m_lo  = b;
        default: ;
      endcase
      m_pos = m_pos + 4'd1;
    end else begin
      // checksum byte closes the frame; bit 7 set can never match
      m_pos = '0;
      if (b != {1'b0, m_sum}) begin
        owe_result(cfp_pkg::KIND_CRC_ERR, 8'h00, 1'b1);
      end else if (!m_report) begin
        if (m_cmd < cfp_pkg::CMD_TALLY_MAX) begin
          m_tally[m_cmd[cfp_pkg::TALLY_IDX_W-1:0]] = {m_hi, m_lo};
          owe_result(cfp_pkg::KIND_SET_OK, 8'h00, 1'b1);
        end else if (m_cmd == cfp_pkg::CMD_CLEAR_ALL) begin
          for (int k = 0; k < cfp_pkg::NUM_TALLIES; k++) m_tally[k] = '0;
          owe_result(cfp_pkg::KIND_SET_OK, 8'h00, 1'b1);
        end else begin
          owe_result(cfp_pkg::KIND_IGNORED, 8'h00, 1'b1);
        end
      end else begin
        // tally message: tag, high, low per tally; tags run 1,1,2,3,4
        for (int k = 0; k < cfp_pkg::NUM_TALLIES; k++) begin
          owe_result(cfp_pkg::KIND_REPORT, (k == 0) ? 8'd1 : 8'(k), 1'b0);
          owe_result(cfp_pkg::KIND_REPORT, m_tally[k][15:8], 1'b0);
          owe_result(cfp_pkg::KIND_REPORT, m_tally[k][7:0],
                     k == cfp_pkg::NUM_TALLIES - 1);
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall and beat-by-beat compare
  // ---------------------------------------------------------------------------

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic report_mismatch(input string what, input int want, input int got);
    if (errors < MAX_PRINTS)
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat, kind", -1, out_kind);
      end else begin
        want = expected_results.pop_front();
        if (out_kind != want.kind) report_mismatch("kind", want.kind, out_kind);
        if (out_byte != want.data) report_mismatch("out_byte", want.data, out_byte);
        if (out_last != want.last) report_mismatch("last", want.last, out_last);
      end
    end
  end

  // hang detection: no handshake on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_counter_frame_parser: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // input side helpers
  // ---------------------------------------------------------------------------

  // one input beat, with a random gap before it in idle phases
  task automatic send_beat(input logic [7:0] b, input logic abort);
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_valid      <= 1'b1;
    in_rx_byte    <= b;
    in_line_abort <= abort;
    do @(posedge clk); while (!in_ready);
    predict_results(b, abort);
  endtask

  // whole frame: opener, command, data high, data low, checksum
  task automatic send_frame(input logic [7:0] opener, input logic [7:0] c,
                            input logic [7:0] h, input logic [7:0] l, input bit good);
    logic [6:0] s;
    logic [7:0] check;
    s = c[6:0] + h[6:0] + l[6:0];
    if (good)
      check = {1'b0, s};
    else if ($urandom_range(1) == 1)
      check = {1'b1, s};
    else
      check = {1'b0, s ^ 7'($urandom_range(127, 1))};
    send_beat(opener, 1'b0);
    send_beat(c, 1'b0);
    send_beat(h, 1'b0);
    send_beat(l, 1'b0);
    send_beat(check, 1'b0);
  endtask

  // hold input off until every owed result is out, then let the block settle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both start bytes, back to back on the config channel
  task automatic write_start_bytes(input logic [7:0] set_val, input logic [7:0] rpt_val);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SET_START;
    cfg_data  <= set_val;
    do @(posedge clk); while (!cfg_ready);
    m_set_start = set_val;
    cfg_index <= REG_REPORT_START;
    cfg_data  <= rpt_val;
    do @(posedge clk); while (!cfg_ready);
    m_report_start = rpt_val;
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed frames, some broken ones, noise and aborts
  task automatic send_random_frame();
    int         pick;
    int         depth;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 45) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: c = 8'($urandom_range(cfp_pkg::NUM_TALLIES - 1));
        6:                c = cfp_pkg::CMD_CLEAR_ALL;
        7:                c = cfp_pkg::CMD_TALLY_MAX;
        8:                c = 8'hFF;
        default:          c = 8'($urandom);
      endcase
      send_frame(m_set_start, c, 8'($urandom), 8'($urandom), 1'b1);
    end else if (pick < 70) begin
      send_frame(m_report_start, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    end else if (pick < 80) begin
      send_frame($urandom_range(1) ? m_set_start : m_report_start,
                 8'($urandom_range(cfp_pkg::NUM_TALLIES - 1)), 8'($urandom),
                 8'($urandom), 1'b0);
    end else if (pick < 90) begin
      send_beat(8'($urandom), 1'b0);
    end else begin
      // abort while waiting (depth 0) or part way into a frame
      depth = $urandom_range(4);
      if (depth > 0) send_beat($urandom_range(1) ? m_set_start : m_report_start, 1'b0);
      for (int i = 1; i < depth; i++) send_beat(8'($urandom), 1'b0);
      send_beat(8'($urandom), 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset start bytes, special cases and field extremes
  task automatic test_directed();
    send_pct  = 0;
    stall_pct = 0;
    send_beat(8'hFF, 1'b0);                          // unknown opener
    send_beat(8'h00, 1'b1);                          // abort while waiting
    send_beat(m_set_start, 1'b0);                    // abort mid-frame
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_frame(m_set_start, 8'h04, 8'hFF, 8'hFF, 1'b1);  // top tally to all ones
    send_beat(m_set_start, 1'b0);                    // checksum with bit 7 set
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h80, 1'b0);
    send_frame(m_set_start, 8'hFF, 8'h00, 8'h01, 1'b1);  // unknown command
    send_frame(m_report_start, 8'h7F, 8'h80, 8'h01, 1'b1);
    wait_for_results();
  endtask

  // same traffic mix under each idle/stall pattern, reset start bytes
  task automatic test_idling();
    int send_mix[4]  = '{0, 85, 0, 30};
    int stall_mix[4] = '{0, 0, 85, 30};
    for (int p = 0; p < 4; p++) begin
      send_pct  = send_mix[p];
      stall_pct = stall_mix[p];
      for (int f = 0; f < 8; f++) send_random_frame();
      // sender holds off here until the block has drained
      wait_for_results();
    end
  endtask

  // start byte extremes, swapped and equal openers, then back to reset values
  task automatic test_config();
    logic [7:0] set_vals[4] = '{8'h00, 8'hFF, 8'h5A, 8'h02};
    logic [7:0] rpt_vals[4] = '{8'hFF, 8'h00, 8'h5A, 8'h03};
    send_pct  = 30;
    stall_pct = 30;
    for (int p = 0; p < 4; p++) begin
      write_start_bytes(set_vals[p], rpt_vals[p]);
      send_frame(m_set_start, cfp_pkg::CMD_CLEAR_ALL, 8'($urandom), 8'($urandom), 1'b1);
      for (int f = 0; f < 6; f++) send_random_frame();
      wait_for_results();
    end
  endtask

  initial begin
    model_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_idling();
    test_config();
    if (errors == 0)
      $display("tb_counter_frame_parser: clean");
    else
      $display("tb_counter_frame_parser: errors");
    $finish;
  end

endmodule
